[hdl/tcw_pkg.sv]
// Shared types, codes and constants of the TSV column width scanner.
package tcw_pkg;

  localparam int MAX_COLUMNS   = 16;
  localparam int MIN_SEPARATOR = 1;
  localparam int MAX_SEPARATOR = 3;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int LEN_W = 16;
  localparam int CNT_W = 5;
  localparam int SEP_W = 2;
  localparam int LIM_W = 5;
  localparam int ACC_W = $clog2(MAX_COLUMNS * (MAX_SEPARATOR + 1) + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // operations
  localparam logic [1:0] OP_SCAN   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIMIT = 2'd1;

  localparam logic [LEN_W-1:0] TABLE_WIDTH_RESET = 16'd80;
  localparam logic [LIM_W-1:0] FIELD_LIMIT_RESET = 5'd16;

  // special characters
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [3:0] column_select;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEP_W-1:0] separator;
    logic [LEN_W-1:0] column_width;
    logic [CNT_W-1:0] column_count;
    logic [LEN_W-1:0] longest_line;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_step;
    logic div_done;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_end;
  } dp_status_t;

endpackage

[hdl/tcw_ram.sv]
// Generic RAM: one write port, two registered read ports.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/tcw_ctrl.sv]
// Controller: sequences accept, execute and the separator search.
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tcw_pkg::dp_status_t sts,
  output tcw_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.needs_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (slot_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (!sts.div_end) begin
          cmd.div_step = 1'b1;
        end else if (slot_free) begin
          cmd.div_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec || cmd.div_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/tcw_dpath.sv]
// Datapath: scan state, column width store, separator search, result register.
module tcw_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  tcw_pkg::cmd_t                       cmd,
  output tcw_pkg::dp_status_t                 sts,
  input  tcw_pkg::item_t                      in_data,
  output tcw_pkg::result_t                    out_data,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int COL_W = tcw_pkg::COL_W;
  localparam int LEN_W = tcw_pkg::LEN_W;
  localparam int CNT_W = tcw_pkg::CNT_W;
  localparam int SEP_W = tcw_pkg::SEP_W;
  localparam int LIM_W = tcw_pkg::LIM_W;
  localparam int ACC_W = tcw_pkg::ACC_W;
  localparam int NCOL  = tcw_pkg::MAX_COLUMNS;

  // configuration
  logic [LEN_W-1:0] table_width;
  logic [LIM_W-1:0] field_limit;

  // captured item
  tcw_pkg::item_t item;

  // scan state
  logic             skip;
  logic [COL_W-1:0] cur_col;
  logic [LEN_W-1:0] field_len;
  logic [LEN_W-1:0] line_len;
  logic [CNT_W-1:0] max_cols;
  logic [LEN_W-1:0] max_line;
  logic             error_flag;
  logic             finished;
  logic [SEP_W-1:0] sep_value;
  logic [NCOL-1:0]  col_valid;

  // separator search
  logic [SEP_W-1:0] div_sep;
  logic [ACC_W-1:0] div_acc;
  logic [LEN_W-1:0] div_diff;

  // width store
  logic [COL_W-1:0] rd_sel;
  logic [LEN_W-1:0] rd_a, rd_b, width_a, width_b;

  // next values
  logic             skip_next;
  logic [COL_W-1:0] cur_col_next;
  logic [LEN_W-1:0] field_len_next, line_len_next, max_line_next;
  logic [CNT_W-1:0] max_cols_next;
  logic             error_next, finished_next;
  logic [SEP_W-1:0] sep_next;
  logic [1:0]       status_next;
  logic             wr_en;
  logic [LEN_W-1:0] col_width_out;

  logic             rejected;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] limit;
  logic             is_tab, is_nl;

  assign rd_sel = cmd.capture ? in_data.column_select[COL_W-1:0]
                              : item.column_select[COL_W-1:0];

  tcw_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NCOL)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (cur_col),
    .wdata   (field_len),
    .raddr_a (cur_col),
    .rdata_a (rd_a),
    .raddr_b (rd_sel),
    .rdata_b (rd_b)
  );

  // a column never written reads as zero
  assign width_a = col_valid[cur_col] ? rd_a : '0;
  assign width_b = col_valid[item.column_select[COL_W-1:0]] ? rd_b : '0;

  assign rejected = error_flag || finished;
  assign col_inc  = CNT_W'(cur_col) + CNT_W'(1);
  assign is_tab   = (item.char_code == tcw_pkg::CH_TAB);
  assign is_nl    = (item.char_code == tcw_pkg::CH_NL);

  always_comb begin
    if (field_limit == '0) begin
      limit = CNT_W'(1);
    end else if (field_limit > LIM_W'(NCOL)) begin
      limit = CNT_W'(NCOL);
    end else begin
      limit = CNT_W'(field_limit);
    end
  end

  assign sts.needs_div = (item.operation == tcw_pkg::OP_FINISH) && !rejected
                         && (max_cols != '0);
  assign sts.div_end   = (div_sep == SEP_W'(tcw_pkg::MAX_SEPARATOR))
                         || (div_diff < LEN_W'(div_acc));

  always_comb begin
    skip_next      = skip;
    cur_col_next   = cur_col;
    field_len_next = field_len;
    line_len_next  = line_len;
    max_cols_next  = max_cols;
    max_line_next  = max_line;
    error_next     = error_flag;
    finished_next  = finished;
    sep_next       = sep_value;
    status_next    = tcw_pkg::ST_OK;
    wr_en          = 1'b0;
    case (item.operation)
      tcw_pkg::OP_SCAN: begin
        if (rejected) begin
          status_next = tcw_pkg::ST_REJECT;
        end else if (skip) begin
          if (is_nl) begin
            skip_next      = 1'b0;
            cur_col_next   = '0;
            field_len_next = '0;
            line_len_next  = '0;
          end
        end else if (line_len == '0 && item.char_code == tcw_pkg::CH_SP) begin
          skip_next = 1'b1;
        end else if (field_len == '0 && item.char_code == tcw_pkg::CH_VT) begin
          // right-justify marker: dropped
        end else if (is_tab || is_nl) begin
          wr_en = cmd.exec && (field_len > width_a);
          if (is_tab && col_inc >= limit) begin
            error_next  = 1'b1;
            status_next = tcw_pkg::ST_OVERFLOW;
          end else begin
            field_len_next = '0;
            if (is_nl) begin
              if (col_inc > max_cols) max_cols_next = col_inc;
              if (line_len > max_line) max_line_next = line_len;
              cur_col_next  = '0;
              line_len_next = '0;
            end else begin
              cur_col_next = col_inc[COL_W-1:0];
            end
          end
        end else begin
          if (field_len != tcw_pkg::LEN_MAX) field_len_next = field_len + 1'b1;
          if (line_len != tcw_pkg::LEN_MAX) line_len_next = line_len + 1'b1;
        end
      end
      tcw_pkg::OP_FINISH: begin
        if (rejected) begin
          status_next = tcw_pkg::ST_REJECT;
        end else begin
          // with columns seen the search supplies the separator
          finished_next = 1'b1;
          sep_next      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign col_width_out = (wr_en && item.column_select[COL_W-1:0] == cur_col)
                         ? field_len : width_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_width <= tcw_pkg::TABLE_WIDTH_RESET;
      field_limit <= tcw_pkg::FIELD_LIMIT_RESET;
      skip        <= 1'b0;
      cur_col     <= '0;
      field_len   <= '0;
      line_len    <= '0;
      max_cols    <= '0;
      max_line    <= '0;
      error_flag  <= 1'b0;
      finished    <= 1'b0;
      sep_value   <= '0;
      col_valid   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::CFG_TABLE_WIDTH: table_width <= cfg_data[LEN_W-1:0];
          tcw_pkg::CFG_FIELD_LIMIT: field_limit <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        skip       <= skip_next;
        cur_col    <= cur_col_next;
        field_len  <= field_len_next;
        line_len   <= line_len_next;
        max_cols   <= max_cols_next;
        max_line   <= max_line_next;
        error_flag <= error_next;
        finished   <= finished_next;
        sep_value  <= sep_next;
      end
      if (wr_en) begin
        col_valid[cur_col] <= 1'b1;
      end
      if (cmd.div_done) begin
        finished  <= 1'b1;
        sep_value <= div_sep;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    // search for the largest k with k * columns <= table_width - longest_line, clamped to 1 to 3
    if (cmd.div_start) begin
      div_sep  <= SEP_W'(tcw_pkg::MIN_SEPARATOR);
      div_acc  <= ACC_W'(max_cols) << 1;
      div_diff <= (table_width > max_line) ? table_width - max_line : '0;
    end else if (cmd.div_step) begin
      div_sep <= div_sep + 1'b1;
      div_acc <= div_acc + ACC_W'(max_cols);
    end
    if (cmd.exec) begin
      out_data.status       <= status_next;
      out_data.separator    <= sep_next;
      out_data.column_width <= col_width_out;
      out_data.column_count <= max_cols_next;
      out_data.longest_line <= max_line_next;
    end else if (cmd.div_done) begin
      out_data.status       <= tcw_pkg::ST_OK;
      out_data.separator    <= div_sep;
      out_data.column_width <= width_b;
      out_data.column_count <= max_cols;
      out_data.longest_line <= max_line;
    end
  end

endmodule

[hdl/tsv_column_width_scanner.sv]
// Top level of the TSV column width scanner: controller, datapath and ports.
// Each input beat is captured in the idle state and executed in the execute
// state once the output register is free; a finish that has columns to divide
// over adds a separator search, which steps one candidate separator per cycle
// through a single compare and add. The result sits in an output register
// until taken; a new beat is accepted meanwhile, and only its execution waits
// for the register to free. Configuration writes are always ready and take
// effect at once.
module tsv_column_width_scanner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tcw_pkg::item_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcw_pkg::result_t               out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcw_pkg::cmd_t       cmd;
  tcw_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[dv/tsv_column_width_scanner_test.sv]
// Self-checking testbench for the TSV column width scanner.
`timescale 1ns / 1ps

module tsv_column_width_scanner_test;
  import tcw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 300;
  localparam int LONG_FIELD = 40;
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TABLE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tsv_column_width_scanner i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  item_t scan_feed[$];
  result_t owed_results[$];
  result_t want_beat;
  int fault_count = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_spent = 1'b0;
  int hold_left = 0;
  bit line_open = 1'b0;

  // scanner state as the block should hold it
  logic [LEN_W-1:0] tw_reg = TABLE_WIDTH_RESET;
  logic [LIM_W-1:0] limit_reg = FIELD_LIMIT_RESET;
  int cur_col = 0;
  logic [LEN_W-1:0] fld_len = '0;
  logic [LEN_W-1:0] line_len = '0;
  logic [LEN_W-1:0] col_widest [MAX_COLUMNS] = '{default: '0};
  logic [CNT_W-1:0] widest_cols = '0;
  logic [LEN_W-1:0] widest_line = '0;
  bit err_seen = 1'b0;
  bit fin_seen = 1'b0;
  logic [SEP_W-1:0] sep_now = '0;

  task automatic report_mismatch(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t ns: %s", $time, msg);
  endtask

  function automatic int limit_of();
    if (limit_reg < 1) return 1;
    if (limit_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(limit_reg);
  endfunction

  function automatic result_t scanner_advance(item_t it);
    result_t r;
    int col;
    int q;
    r = '0;
    r.status = ST_OK;
    if (it.operation == OP_SCAN || it.operation == OP_FINISH) begin
      if (err_seen || fin_seen) begin
        r.status = ST_REJECT;
      end else if (it.operation == OP_FINISH) begin
        fin_seen = 1'b1;
        if (widest_cols == 0) begin
          sep_now = '0;
        end else begin
          if (tw_reg <= widest_line) q = 0;
          else q = (int'(tw_reg) - int'(widest_line)) / int'(widest_cols);
          if (q < MIN_SEPARATOR) q = MIN_SEPARATOR;
          if (q > MAX_SEPARATOR) q = MAX_SEPARATOR;
          sep_now = SEP_W'(q);
        end
      end else if (cur_col < 0) begin
        // comment line: only its newline matters
        if (it.char_code == CH_NL) begin
          cur_col = 0;
          fld_len = '0;
          line_len = '0;
        end
      end else if (line_len == 0 && it.char_code == CH_SP) begin
        cur_col = -1;
      end else if (!(fld_len == 0 && it.char_code == CH_VT)) begin
        if (it.char_code == CH_TAB || it.char_code == CH_NL) begin
          col = cur_col;
          if (col < MAX_COLUMNS && fld_len > col_widest[col]) col_widest[col] = fld_len;
          col++;
          if (it.char_code == CH_TAB && col >= limit_of()) begin
            err_seen = 1'b1;
            r.status = ST_OVERFLOW;
          end else begin
            fld_len = '0;
            cur_col = col;
            if (it.char_code == CH_NL) begin
              if (col > int'(widest_cols)) widest_cols = CNT_W'(col);
              if (line_len > widest_line) widest_line = line_len;
              cur_col = 0;
              line_len = '0;
            end
          end
        end else begin
          if (fld_len != LEN_MAX) fld_len++;
          if (line_len != LEN_MAX) line_len++;
        end
      end
    end
    r.separator = sep_now;
    r.column_width = col_widest[it.column_select];
    r.column_count = widest_cols;
    r.longest_line = widest_line;
    return r;
  endfunction

  function automatic void push_op(logic [1:0] op, logic [7:0] ch, logic [3:0] sel);
    item_t it;
    it.operation = op;
    it.char_code = ch;
    it.column_select = sel;
    scan_feed.push_back(it);
  endfunction

  // text byte: never a tab or newline, spaces and vertical tabs often
  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, 1) ? CH_VT : CH_SP;
    c = 8'($urandom_range(1, 255));
    while (c == CH_TAB || c == CH_NL) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // a scan beat, now and then preceded by a read or an unused operation
  function automatic void push_scan(logic [7:0] ch);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) push_op(OP_READ, 8'($urandom()), 4'($urandom()));
    else if (roll < 8) push_op(OP_UNUSED, 8'($urandom()), 4'($urandom()));
    push_op(OP_SCAN, ch, 4'($urandom()));
  endfunction

  // tabs per line stay under the limit so the scan never errors early
  function automatic void push_line(int lim);
    int kind;
    int ncols;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      if (line_open) push_scan(CH_NL);
      push_scan(CH_SP);
      len = $urandom_range(0, 10);
      repeat (len) push_scan($urandom_range(0, 3) == 0 ? CH_TAB : pick_text_char());
      push_scan(CH_NL);
      line_open = 1'b0;
    end else if (kind < 15) begin
      repeat ($urandom_range(1, 6)) push_scan(pick_text_char());
      if ($urandom_range(0, 1)) begin
        push_scan(CH_NL);
        line_open = 1'b0;
      end else begin
        line_open = 1'b1;
      end
    end else begin
      ncols = $urandom_range(1, lim);
      for (int f = 0; f < ncols; f++) begin
        if (f != 0) push_scan(CH_TAB);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_scan(CH_VT);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
        repeat (len) push_scan(pick_text_char());
      end
      push_scan(CH_NL);
      line_open = 1'b0;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TABLE_WIDTH) tw_reg = val;
    else if (idx == CFG_FIELD_LIMIT) limit_reg = val[LIM_W-1:0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (scan_feed.size() != 0 || in_valid || owed_results.size() != 0) @(negedge clk);
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) owed_results.push_back(scanner_advance(in_data));
      if (scan_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
        in_data <= scan_feed.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go && !hold_spent) begin
      hold_left <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with nothing owed");
        end else begin
          want_beat = owed_results.pop_front();
          if (out_data.status !== want_beat.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_data.status, want_beat.status));
          if (out_data.separator !== want_beat.separator)
            report_mismatch($sformatf("separator %0d, want %0d",
                                      out_data.separator, want_beat.separator));
          if (out_data.column_width !== want_beat.column_width)
            report_mismatch($sformatf("column_width %0d, want %0d",
                                      out_data.column_width, want_beat.column_width));
          if (out_data.column_count !== want_beat.column_count)
            report_mismatch($sformatf("column_count %0d, want %0d",
                                      out_data.column_count, want_beat.column_count));
          if (out_data.longest_line !== want_beat.longest_line)
            report_mismatch($sformatf("longest_line %0d, want %0d",
                                      out_data.longest_line, want_beat.longest_line));
        end
      end
      out_stall <= hold_left != 0 || (!calm && $urandom_range(0, 99) < 26);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] tw_val;
    logic [CFG_DATA_W-1:0] lim_val;
    int t;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    push_op(OP_READ, 8'hFF, 4'd0);
    push_op(OP_UNUSED, 8'h01, 4'd15);
    push_op(OP_SCAN, CH_VT, 4'd0);     // marker, dropped
    push_op(OP_SCAN, 8'h01, 4'd0);
    push_op(OP_SCAN, CH_VT, 4'd0);     // mid-field, counted
    push_op(OP_SCAN, 8'hFF, 4'd15);
    push_op(OP_SCAN, CH_TAB, 4'd0);
    push_op(OP_SCAN, CH_SP, 4'd1);     // mid-line space counts
    push_op(OP_SCAN, CH_NL, 4'd1);
    push_op(OP_SCAN, CH_SP, 4'd0);     // comment line
    push_op(OP_SCAN, CH_TAB, 4'd0);
    push_op(OP_SCAN, 8'h61, 4'd0);
    push_op(OP_SCAN, CH_NL, 4'd0);
    push_op(OP_SCAN, CH_TAB, 4'd0);    // empty first field
    push_op(OP_SCAN, 8'h7A, 4'd1);
    push_op(OP_SCAN, CH_TAB, 4'd1);
    push_op(OP_SCAN, CH_NL, 4'd2);
    push_op(OP_READ, 8'h00, 4'd0);
    push_op(OP_READ, 8'h55, 4'd1);
    push_op(OP_READ, 8'hAA, 4'd2);
    push_op(OP_READ, 8'hFF, 4'd15);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      lim_val = 16'($urandom());
      case (p)
        0: begin tw_val = 16'hFFFF; lim_val[LIM_W-1:0] = 5'd31; end
        1: begin tw_val = 16'd1; lim_val[LIM_W-1:0] = 5'd16; end
        2: begin tw_val = 16'($urandom()); lim_val[LIM_W-1:0] = 5'd0; end
        3: begin
          tw_val = 16'($urandom_range(1, 200));
          lim_val[LIM_W-1:0] = 5'($urandom_range(2, 15));
        end
        4: begin tw_val = TABLE_WIDTH_RESET; lim_val[LIM_W-1:0] = 5'd1; end
        default: begin
          tw_val = 16'($urandom());
          lim_val[LIM_W-1:0] = 5'($urandom_range(17, 30));
        end
      endcase
      write_reg(CFG_TABLE_WIDTH, tw_val);
      write_reg(CFG_FIELD_LIMIT, lim_val);
      if (p == 2) write_reg(CFG_SPARE_A, 16'($urandom()));
      if (p == 4) write_reg(CFG_SPARE_B, 16'($urandom()));
      @(negedge clk);
      calm <= (p == 1);
      while (scan_feed.size() < PHASE_BEATS) push_line(limit_of());
      // receiver sits on a full block while beats keep coming
      if (p == 3) hold_go <= 1'b1;
      wait_drained();
    end
    calm <= 1'b0;

    case ($urandom_range(0, 3))
      0: tw_val = 16'd1;
      1: tw_val = 16'hFFFF;
      2: begin
        t = int'(widest_line) + $urandom_range(0, 60);
        if (t > 65535) t = 65535;
        tw_val = 16'(t);
      end
      default: tw_val = 16'($urandom_range(1, 65535));
    endcase
    write_reg(CFG_TABLE_WIDTH, tw_val);

    if ($urandom_range(0, 1)) begin
      // long line, then a line with one tab too many
      lim_val = 16'($urandom());
      lim_val[LIM_W-1:0] = 5'($urandom_range(1, 16));
      write_reg(CFG_FIELD_LIMIT, lim_val);
      @(negedge clk);
      push_op(OP_SCAN, CH_NL, 4'($urandom()));
      push_op(OP_SCAN, 8'h61, 4'($urandom()));
      repeat (LONG_FIELD) push_op(OP_SCAN, pick_text_char(), 4'($urandom()));
      push_op(OP_SCAN, CH_NL, 4'($urandom()));
      for (int f = 0; f < limit_of(); f++) begin
        push_op(OP_SCAN, 8'h62, 4'($urandom()));
        push_op(OP_SCAN, CH_TAB, 4'($urandom()));
      end
    end else begin
      // unterminated line, then finish
      @(negedge clk);
      push_op(OP_SCAN, 8'h63, 4'($urandom()));
      repeat ($urandom_range(0, 5)) push_op(OP_SCAN, pick_text_char(), 4'($urandom()));
      push_op(OP_FINISH, 8'($urandom()), 4'($urandom()));
    end
    // scans and finishes are now refused; reads and unused operations are not
    push_op(OP_SCAN, CH_TAB, 4'($urandom()));
    push_op(OP_SCAN, CH_NL, 4'($urandom()));
    push_op(OP_SCAN, 8'h78, 4'($urandom()));
    push_op(OP_SCAN, CH_VT, 4'($urandom()));
    push_op(OP_FINISH, 8'($urandom()), 4'($urandom()));
    push_op(OP_UNUSED, 8'($urandom()), 4'($urandom()));
    for (int c = 0; c < MAX_COLUMNS; c++) push_op(OP_READ, 8'($urandom()), 4'(c));
    wait_drained();
    repeat (20) @(posedge clk);

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_dpath.sv
hdl/tsv_column_width_scanner.sv
dv/tsv_column_width_scanner_test.sv
